@@ hdl/csl_pkg.sv @@
package csl_pkg;

  // Coordinate width, signed fixed point with 4 fraction bits at the default
  localparam int COORD_WIDTH = 16;
  // Product and quotient width of the intersection term
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  // Division step counter, wide enough to hold the step count itself
  localparam int STEP_WIDTH  = $clog2(PROD_WIDTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0]   diff_t;
  typedef logic        [COORD_WIDTH-1:0] mag_t;
  typedef logic        [PROD_WIDTH-1:0]  prod_t;

endpackage

@@ hdl/csl_muldiv.sv @@
module csl_muldiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  csl_pkg::mag_t        a_i,
  input  csl_pkg::mag_t        b_i,
  input  csl_pkg::mag_t        d_i,
  output logic                 done_o,
  output csl_pkg::prod_t       quot_o
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;

  localparam int CW = csl_pkg::COORD_WIDTH;
  localparam int PW = csl_pkg::PROD_WIDTH;
  localparam int SW = csl_pkg::STEP_WIDTH;

  logic [1:0]          state_q, state_d;
  logic [SW-1:0]       cnt_q, cnt_d;
  logic                done_q, done_d;
  csl_pkg::mag_t       a_q, b_q, d_q;
  csl_pkg::mag_t       rem_q, rem_d;
  csl_pkg::prod_t      acc_q, acc_d;
  logic [CW:0]         rem_shift;
  logic [CW:0]         rem_sub;
  logic                ge;

  // One restoring division step: shift in the next dividend bit, try a subtract
  assign rem_shift = {rem_q, acc_q[PW-1]};
  assign ge        = rem_shift >= {1'b0, d_q};
  assign rem_sub   = rem_shift - {1'b0, d_q};

  // Sequence: latch operands, multiply once, then divide one bit a cycle
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    acc_d   = acc_q;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        acc_d   = PW'(a_q * b_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = U_DIV;
      end
      U_DIV: begin
        rem_d = ge ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
        acc_d = {acc_q[PW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SW'(PW - 1)) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Hold operands and the working registers
  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      d_q <= d_i;
    end
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

@@ hdl/cohen_sutherland_line_clip.sv @@
// Each boundary move runs the serial divider of the shared multiply-divide unit, unless
// the divisor is zero; a trivial accept or reject makes no move, and there are at most four.
// Throughput: one segment is in work at a time and the next input is taken the cycle after
// the result is loaded.
// Reset clears control state and loads the window with left -80, right 80, bottom -80, top 80.
module cohen_sutherland_line_clip (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  csl_pkg::coord_t     cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  csl_pkg::coord_t     start_x_i,
  input  csl_pkg::coord_t     start_y_i,
  input  csl_pkg::coord_t     end_x_i,
  input  csl_pkg::coord_t     end_y_i,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                accepted_o,
  output csl_pkg::coord_t     clipped_start_x_o,
  output csl_pkg::coord_t     clipped_start_y_o,
  output csl_pkg::coord_t     clipped_end_x_o,
  output csl_pkg::coord_t     clipped_end_y_o
);

  localparam int CW = csl_pkg::COORD_WIDTH;
  localparam int PW = csl_pkg::PROD_WIDTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  localparam int RC_LEFT   = 0;
  localparam int RC_RIGHT  = 1;
  localparam int RC_BOTTOM = 2;
  localparam int RC_TOP    = 3;

  localparam logic [2:0] MAX_CLIPS = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [2:0]         clips_q;
  logic               acc_q;
  csl_pkg::coord_t    win_left_q, win_right_q, win_bottom_q, win_top_q;
  csl_pkg::coord_t    x0_q, y0_q, x1_q, y1_q;
  csl_pkg::coord_t    a0_q, bound_q;
  csl_pkg::diff_t     da_q, n2_q, db_q;
  logic               horiz_q, mv_end_q;
  logic               out_valid_q;
  logic               out_acc_q;
  csl_pkg::coord_t    out_x0_q, out_y0_q, out_x1_q, out_y1_q;

  logic [3:0]         c0, c1, oc;
  csl_pkg::diff_t     dx, dy;
  logic               unit_start, unit_done;
  csl_pkg::prod_t     unit_quot, q_sel;
  logic               apply;
  logic               load_out;
  logic signed [PW+1:0] sum;
  csl_pkg::coord_t    new_c, nx, ny;

  function automatic logic [3:0] region(csl_pkg::coord_t x, csl_pkg::coord_t y,
                                        csl_pkg::coord_t wl, csl_pkg::coord_t wr,
                                        csl_pkg::coord_t wb, csl_pkg::coord_t wt);
    logic [3:0] c;
    c = '0;
    if (x < wl) c[RC_LEFT] = 1'b1;
    else if (x > wr) c[RC_RIGHT] = 1'b1;
    if (y < wb) c[RC_BOTTOM] = 1'b1;
    else if (y > wt) c[RC_TOP] = 1'b1;
    return c;
  endfunction

  function automatic csl_pkg::mag_t mag(csl_pkg::diff_t v);
    csl_pkg::diff_t n;
    n = -v;
    return v[CW] ? n[CW-1:0] : v[CW-1:0];
  endfunction

  // Region codes of both endpoints and the code to act on
  assign c0 = region(x0_q, y0_q, win_left_q, win_right_q, win_bottom_q, win_top_q);
  assign c1 = region(x1_q, y1_q, win_left_q, win_right_q, win_bottom_q, win_top_q);
  assign oc = (c0 != 4'd0) ? c0 : c1;
  assign dx = {x1_q[CW-1], x1_q} - {x0_q[CW-1], x0_q};
  assign dy = {y1_q[CW-1], y1_q} - {y0_q[CW-1], y0_q};

  csl_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .a_i     (mag(da_q)),
    .b_i     (mag(n2_q)),
    .d_i     (mag(db_q)),
    .done_o  (unit_done),
    .quot_o  (unit_quot)
  );

  // Intersection: a0 plus or minus the quotient, saturated to the coordinate range
  assign q_sel = (state_q == S_START) ? '0 : unit_quot;
  always_comb begin
    if (da_q[CW] ^ n2_q[CW] ^ db_q[CW]) begin
      sum = {{(PW+2-CW){a0_q[CW-1]}}, a0_q} - {2'b00, q_sel};
    end else begin
      sum = {{(PW+2-CW){a0_q[CW-1]}}, a0_q} + {2'b00, q_sel};
    end
    if (sum[PW+1:CW-1] != '0 && sum[PW+1:CW-1] != '1) begin
      new_c = sum[PW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      new_c = sum[CW-1:0];
    end
    nx = horiz_q ? new_c : bound_q;
    ny = horiz_q ? bound_q : new_c;
  end

  assign unit_start = (state_q == S_START) && (db_q != '0);
  assign apply      = ((state_q == S_START) && (db_q == '0)) ||
                      ((state_q == S_WAIT) && unit_done);
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready);

  // Sequencer: decide, run the shared unit unless the divisor is zero, move the endpoint, repeat
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if ((c0 | c1) == 4'd0 || (c0 & c1) != 4'd0 || clips_q == MAX_CLIPS) begin
          state_d = S_DONE;
        end else begin
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = (db_q == '0) ? S_DECIDE : S_WAIT;
      end
      S_WAIT: begin
        if (unit_done) state_d = S_DECIDE;
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      clips_q      <= '0;
      out_valid_q  <= 1'b0;
      win_left_q   <= -CW'(80);
      win_right_q  <= CW'(80);
      win_bottom_q <= -CW'(80);
      win_top_q    <= CW'(80);
    end else begin
      state_q <= state_d;
      // Count boundary moves per segment
      if (state_q == S_IDLE) begin
        clips_q <= '0;
      end else if (apply) begin
        clips_q <= clips_q + 1'b1;
      end
      // Hold the result until its transaction completes
      out_valid_q <= load_out | (out_valid_q & ~out_ready);
      // Write window registers
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LEFT:   win_left_q   <= cfg_data;
          REG_RIGHT:  win_right_q  <= cfg_data;
          REG_BOTTOM: win_bottom_q <= cfg_data;
          REG_TOP:    win_top_q    <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  // Payload registers: endpoints, operands and the output stage
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid) begin
      x0_q <= start_x_i;
      y0_q <= start_y_i;
      x1_q <= end_x_i;
      y1_q <= end_y_i;
    end else if (apply) begin
      if (mv_end_q) begin
        x1_q <= nx;
        y1_q <= ny;
      end else begin
        x0_q <= nx;
        y0_q <= ny;
      end
    end
    if (state_q == S_DECIDE) begin
      acc_q    <= ((c0 | c1) == 4'd0);
      mv_end_q <= (c0 == 4'd0);
      if (oc[RC_TOP] || oc[RC_BOTTOM]) begin
        horiz_q <= 1'b1;
        a0_q    <= x0_q;
        bound_q <= oc[RC_TOP] ? win_top_q : win_bottom_q;
        da_q    <= dx;
        db_q    <= dy;
        n2_q    <= (oc[RC_TOP] ? {win_top_q[CW-1], win_top_q}
                               : {win_bottom_q[CW-1], win_bottom_q}) - {y0_q[CW-1], y0_q};
      end else begin
        horiz_q <= 1'b0;
        a0_q    <= y0_q;
        bound_q <= oc[RC_RIGHT] ? win_right_q : win_left_q;
        da_q    <= dy;
        db_q    <= dx;
        n2_q    <= (oc[RC_RIGHT] ? {win_right_q[CW-1], win_right_q}
                                 : {win_left_q[CW-1], win_left_q}) - {x0_q[CW-1], x0_q};
      end
    end
    if (load_out) begin
      out_acc_q <= acc_q;
      out_x0_q  <= acc_q ? x0_q : '0;
      out_y0_q  <= acc_q ? y0_q : '0;
      out_x1_q  <= acc_q ? x1_q : '0;
      out_y1_q  <= acc_q ? y1_q : '0;
    end
  end

  assign cfg_ready         = 1'b1;
  assign in_ready          = (state_q == S_IDLE);
  assign out_valid         = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign clipped_start_x_o = out_x0_q;
  assign clipped_start_y_o = out_y0_q;
  assign clipped_end_x_o   = out_x1_q;
  assign clipped_end_y_o   = out_y1_q;

endmodule

@@ test/cohen_sutherland_line_clip_tb.sv @@
module cohen_sutherland_line_clip_tb;

  typedef csl_pkg::coord_t coord_t;
  localparam int COORD_WIDTH = csl_pkg::COORD_WIDTH;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_WIDTH - 1));

  // Region code bits of an endpoint
  localparam bit [3:0] REGION_LEFT   = 4'd1;
  localparam bit [3:0] REGION_RIGHT  = 4'd2;
  localparam bit [3:0] REGION_BOTTOM = 4'd4;
  localparam bit [3:0] REGION_TOP    = 4'd8;
  localparam int       MAX_MOVES     = 4;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 210;
  localparam int HOLD_AFTER   = 300;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 160;
  localparam int STALL_LIMIT  = 5000;
  localparam int REPORT_LIMIT = 100;

  typedef enum logic [1:0] {
    WIN_LEFT   = 2'd0,
    WIN_RIGHT  = 2'd1,
    WIN_BOTTOM = 2'd2,
    WIN_TOP    = 2'd3
  } win_reg_e;

  typedef struct {
    bit     accepted;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } clip_result_t;

  typedef struct {
    bit           given;
    clip_result_t value;
  } answer_t;

  typedef enum bit {ROW_WINDOW, ROW_SEGMENT} row_kind_e;

  // Window rows carry left, right, bottom, top; segment rows carry start and end
  typedef struct {
    row_kind_e    kind;
    coord_t       a;
    coord_t       b;
    coord_t       c;
    coord_t       d;
    bit           given;
    clip_result_t want;
  } dir_row_t;

  localparam clip_result_t NO_CLIP = '{1'b0, 0, 0, 0, 0};
  localparam int DIRECTED_ROWS = 29;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_SEGMENT, 0, 0, 16, -16, 1'b1, '{1'b1, 0, 0, 16, -16}},
    '{ROW_SEGMENT, -80, -80, 80, 80, 1'b1, '{1'b1, -80, -80, 80, 80}},
    '{ROW_SEGMENT, 0, 100, 40, 200, 1'b1, NO_CLIP},
    '{ROW_SEGMENT, -200, 0, -100, 50, 1'b1, NO_CLIP},
    '{ROW_SEGMENT, 32767, 32767, 32767, -32768, 1'b1, NO_CLIP},
    '{ROW_SEGMENT, -32768, -32768, -32768, -32768, 1'b1, NO_CLIP},
    '{ROW_SEGMENT, -200, 0, 200, 0, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, 0, -200, 0, 200, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -32768, -32768, 32767, 32767, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -32768, 32767, 32767, -32768, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -200, 60, -60, 200, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, 10, 20, 300, -170, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -123, 45, 67, -301, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, 5, 5, 5, 5, 1'b1, '{1'b1, 5, 5, 5, 5}},
    '{ROW_WINDOW, -32768, 32767, -32768, 32767, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -32768, -32768, 32767, 32767, 1'b1,
      '{1'b1, -32768, -32768, 32767, 32767}},
    '{ROW_SEGMENT, 32767, -32768, -32768, 32767, 1'b1,
      '{1'b1, 32767, -32768, -32768, 32767}},
    '{ROW_WINDOW, 0, 0, 0, 0, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -16, -16, 16, 16, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, 0, 0, 0, 0, 1'b1, '{1'b1, 0, 0, 0, 0}},
    '{ROW_WINDOW, 100, -100, 100, -100, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, 0, 0, 50, 30, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -300, 17, 250, -90, 1'b0, NO_CLIP},
    '{ROW_WINDOW, 32767, -32768, 32767, -32768, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -32768, -32768, 32767, 32767, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, 0, 32767, 32767, 0, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -1, -1, 1, 1, 1'b0, NO_CLIP},
    '{ROW_WINDOW, -80, 80, -80, 80, 1'b0, NO_CLIP},
    '{ROW_SEGMENT, -1, -1, -1, -1, 1'b1, '{1'b1, -1, -1, -1, -1}}
  };

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic   [1:0] cfg_index = WIN_LEFT;
  coord_t cfg_data = '0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   accepted_o;
  coord_t clipped_start_x_o;
  coord_t clipped_start_y_o;
  coord_t clipped_end_x_o;
  coord_t clipped_end_y_o;

  // Local copy of the window, written only while the block is idle
  coord_t win_left = -80;
  coord_t win_right = 80;
  coord_t win_bottom = -80;
  coord_t win_top = 80;

  clip_result_t pending_clips[$];
  answer_t      row_answers[$];

  int  fail_count = 0;
  int  segment_count = 0;
  int  result_count = 0;
  int  accept_count = 0;
  int  window_count = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  bit  hold_done = 1'b0;

  cohen_sutherland_line_clip dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .accepted_o        (accepted_o),
    .clipped_start_x_o (clipped_start_x_o),
    .clipped_start_y_o (clipped_start_y_o),
    .clipped_end_x_o   (clipped_end_x_o),
    .clipped_end_y_o   (clipped_end_y_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Region code of a point against the current window
  function automatic bit [3:0] region_code(longint x, longint y);
    bit [3:0] code;
    code = '0;
    if (x < longint'(win_left)) code |= REGION_LEFT;
    else if (x > longint'(win_right)) code |= REGION_RIGHT;
    if (y < longint'(win_bottom)) code |= REGION_BOTTOM;
    else if (y > longint'(win_top)) code |= REGION_TOP;
    return code;
  endfunction

  // a0 + da * (bound - b0) / db, quotient truncated toward zero, saturated
  function automatic longint boundary_cross(longint a0, longint da, longint bound,
                                            longint b0, longint db);
    longint span_b;
    longint quot;
    longint res;
    span_b = bound - b0;
    if (db == 0) return a0;
    quot = ((da < 0 ? -da : da) * (span_b < 0 ? -span_b : span_b)) / (db < 0 ? -db : db);
    res = (((da < 0) ^ (span_b < 0)) ^ (db < 0)) ? a0 - quot : a0 + quot;
    if (res > COORD_MAX) res = COORD_MAX;
    if (res < COORD_MIN) res = COORD_MIN;
    return res;
  endfunction

  // Expected clip of one segment against the current window
  function automatic clip_result_t clip_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint x0, y0, x1, y1, nx, ny;
    bit [3:0] c0, c1, oc;
    int moves;
    clip_result_t res;
    x0 = sx;
    y0 = sy;
    x1 = ex;
    y1 = ey;
    c0 = region_code(x0, y0);
    c1 = region_code(x1, y1);
    moves = 0;
    res = NO_CLIP;
    while (1'b1) begin
      if ((c0 | c1) == 4'd0) begin
        res = '{1'b1, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1)};
        break;
      end
      // give up once the codes share a side or the move budget is spent
      if ((c0 & c1) != 4'd0 || moves == MAX_MOVES) break;
      moves++;
      oc = (c0 != 4'd0) ? c0 : c1;
      if ((oc & REGION_TOP) != 4'd0) begin
        ny = win_top;
        nx = boundary_cross(x0, x1 - x0, ny, y0, y1 - y0);
      end else if ((oc & REGION_BOTTOM) != 4'd0) begin
        ny = win_bottom;
        nx = boundary_cross(x0, x1 - x0, ny, y0, y1 - y0);
      end else if ((oc & REGION_RIGHT) != 4'd0) begin
        nx = win_right;
        ny = boundary_cross(y0, y1 - y0, nx, x0, x1 - x0);
      end else begin
        nx = win_left;
        ny = boundary_cross(y0, y1 - y0, nx, x0, x1 - x0);
      end
      if (c0 != 4'd0) begin
        x0 = nx;
        y0 = ny;
        c0 = region_code(x0, y0);
      end else begin
        x1 = nx;
        y1 = ny;
        c1 = region_code(x1, y1);
      end
    end
    return res;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // Most often near the window span, some full range, some on edges and extremes
  function automatic coord_t pick_coord(coord_t e0, coord_t e1);
    longint lo, hi, span;
    int pick;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      span = (hi - lo) / 2 + 64;
      return clamp_coord(rand_between(lo - span, hi + span));
    end
    if (pick < 70) return coord_t'($urandom);
    if (pick < 85) begin
      unique case ($urandom_range(0, 3))
        0: return clamp_coord(lo);
        1: return clamp_coord(hi);
        2: return clamp_coord(lo - 1);
        default: return clamp_coord(hi + 1);
      endcase
    end
    unique case ($urandom_range(0, 3))
      0: return coord_t'(COORD_MIN);
      1: return coord_t'(COORD_MAX);
      2: return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  // Idle length for either side: mostly none, some short, a few long
  function automatic int gap_len();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 96) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_field(input string name, input logic signed [COORD_WIDTH:0] want,
                              input logic signed [COORD_WIDTH:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic write_reg(input win_reg_e idx, input coord_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    unique case (idx)
      WIN_LEFT:   win_left = value;
      WIN_RIGHT:  win_right = value;
      WIN_BOTTOM: win_bottom = value;
      default:    win_top = value;
    endcase
  endtask

  task automatic set_window(input coord_t l, input coord_t r, input coord_t b, input coord_t t);
    write_reg(WIN_LEFT, l);
    write_reg(WIN_RIGHT, r);
    write_reg(WIN_BOTTOM, b);
    write_reg(WIN_TOP, t);
    cfg_valid <= 1'b0;
    window_count++;
  endtask

  // Stop offering and wait until every outstanding clip has come back
  task automatic drain_clips();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_clips.size() != 0) @(posedge clk_i);
  endtask

  task automatic hold_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic send_segment(input coord_t sx, input coord_t sy, input coord_t ex,
                              input coord_t ey, input bit given, input clip_result_t want);
    row_answers.push_back('{given, want});
    in_valid  <= 1'b1;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i   <= ex;
    end_y_i   <= ey;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Predict on every input transaction, check every output transaction
  always @(posedge clk_i) begin : result_check
    answer_t      tag;
    clip_result_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        tag = row_answers.pop_front();
        if (tag.given) pending_clips.push_back(tag.value);
        else pending_clips.push_back(clip_segment(start_x_i, start_y_i, end_x_i, end_y_i));
        segment_count++;
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (accepted_o === 1'b1) accept_count++;
        if (pending_clips.size() == 0) begin
          fail_count++;
          $error("result transaction with no segment outstanding");
        end else begin
          want = pending_clips.pop_front();
          report_field("accepted", want.accepted, accepted_o);
          report_field("clipped_start_x", want.start_x, clipped_start_x_o);
          report_field("clipped_start_y", want.start_y, clipped_start_y_o);
          report_field("clipped_end_x", want.end_x, clipped_end_x_o);
          report_field("clipped_end_y", want.end_y, clipped_end_y_o);
        end
      end
    end
  end

  // Abort when no channel has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("cohen_sutherland_line_clip_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off to back up the input
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (!hold_done && result_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        stall = gap_len();
        if (stall == 0) begin
          out_ready <= 1'b1;
          @(posedge clk_i);
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    coord_t l, r, b, t;
    longint u, v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, the first ones against the window left by reset
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_WINDOW) begin
        drain_clips();
        set_window(row.a, row.b, row.c, row.d);
      end else begin
        hold_input(gap_len());
        send_segment(row.a, row.b, row.c, row.d, row.given, row.want);
      end
    end

    // Random segments, one window setting per phase
    for (int p = 0; p < PHASES; p++) begin
      drain_clips();
      unique case (p)
        0: begin
          l = clamp_coord(rand_between(-2000, 0));
          r = clamp_coord(rand_between(0, 2000));
          b = clamp_coord(rand_between(-2000, 0));
          t = clamp_coord(rand_between(0, 2000));
        end
        1: begin
          u = coord_t'($urandom);
          v = coord_t'($urandom);
          l = clamp_coord(u < v ? u : v);
          r = clamp_coord(u < v ? v : u);
          u = coord_t'($urandom);
          v = coord_t'($urandom);
          b = clamp_coord(u < v ? u : v);
          t = clamp_coord(u < v ? v : u);
        end
        2: begin
          l = clamp_coord(COORD_MIN);
          r = clamp_coord(COORD_MAX);
          b = clamp_coord(COORD_MIN);
          t = clamp_coord(COORD_MAX);
        end
        3: begin
          // inverted window: drives the move budget and saturation
          l = clamp_coord(rand_between(0, 3000));
          r = clamp_coord(rand_between(-3000, -1));
          b = clamp_coord(rand_between(0, 3000));
          t = clamp_coord(rand_between(-3000, -1));
        end
        4: begin
          l = clamp_coord(rand_between(-1000, 1000));
          r = l;
          b = clamp_coord(rand_between(-1000, 1000));
          t = b;
        end
        5: begin
          l = clamp_coord(rand_between(-20000, 10000));
          r = clamp_coord(l + rand_between(0, 5000));
          b = clamp_coord(rand_between(-20000, 10000));
          t = clamp_coord(b + rand_between(0, 5000));
        end
        6: begin
          l = coord_t'($urandom);
          r = coord_t'($urandom);
          b = coord_t'($urandom);
          t = coord_t'($urandom);
        end
        default: begin
          l = -80;
          r = 80;
          b = -80;
          t = 80;
        end
      endcase
      set_window(l, r, b, t);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) calm = !calm;
        hold_input(gap_len());
        send_segment(pick_coord(win_left, win_right), pick_coord(win_bottom, win_top),
                     pick_coord(win_left, win_right), pick_coord(win_bottom, win_top),
                     1'b0, NO_CLIP);
      end
    end

    drain_clips();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_clips.size() != 0) begin
      fail_count++;
      $error("%0d clips never came back", pending_clips.size());
    end

    $display("clipped %0d segments (%0d inside, %0d rejected) over %0d window settings",
             segment_count, accept_count, result_count - accept_count, window_count);
    $display("window settings included reset, full range, zero size and inverted edges");
    if (fail_count == 0) begin
      $display("cohen_sutherland_line_clip_tb passed");
    end else begin
      $display("cohen_sutherland_line_clip_tb failed");
    end
    $finish;
  end

endmodule
